// File: rtl/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_C0_C1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_C00   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_C10   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_C01   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_C11   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_C20   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_C21   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_C30   = CFG_IDX_W'(7);

  // Stream payloads.
  localparam int RAW_W      = 24;
  localparam int IN_DATA_W  = 48;
  localparam int TEMP_W     = 25;
  localparam int PRES_W     = 32;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - TEMP_W - PRES_W;

  // Queue between the front end and the arithmetic engine (power of two).
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } bsc_coef_t;

  // One classified sample: raw temperature, scaled pressure (Q30) and the
  // finished temperature result.
  typedef struct packed {
    logic signed [RAW_W-1:0]  traw;
    logic signed [31:0]       psc;
    logic signed [TEMP_W-1:0] tout;
  } bsc_item_t;

endpackage

`default_nettype wire

// File: rtl/bsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire bsc_pkg::bsc_coef_t             coef,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [bsc_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                item_valid,
  input  wire                                 item_ready,
  output bsc_pkg::bsc_item_t                  item
);
  import bsc_pkg::*;

  localparam logic [24:0] POFFSET = 25'd15728640;  // 15 * 2^20
  localparam logic [25:0] RECIP15 = 26'd35791394;  // floor(2^29 / 15)
  localparam logic [31:0] QBIAS   = 32'd1048576;   // 2^20

  // floor(2048 * b / 15) for a remainder b of a division by 15.
  function automatic logic [10:0] frac_tab(input logic [3:0] b);
    case (b)
      4'd0:    frac_tab = 11'd0;
      4'd1:    frac_tab = 11'd136;
      4'd2:    frac_tab = 11'd273;
      4'd3:    frac_tab = 11'd409;
      4'd4:    frac_tab = 11'd546;
      4'd5:    frac_tab = 11'd682;
      4'd6:    frac_tab = 11'd819;
      4'd7:    frac_tab = 11'd955;
      4'd8:    frac_tab = 11'd1092;
      4'd9:    frac_tab = 11'd1228;
      4'd10:   frac_tab = 11'd1365;
      4'd11:   frac_tab = 11'd1501;
      4'd12:   frac_tab = 11'd1638;
      4'd13:   frac_tab = 11'd1774;
      4'd14:   frac_tab = 11'd1911;
      default: frac_tab = 11'd0;
    endcase
  endfunction

  logic                    s1_vld_r;
  logic signed [RAW_W-1:0] s1_praw_r;
  logic signed [RAW_W-1:0] s1_traw_r;
  logic                    s2_vld_r;
  logic [24:0]             s2_pofs_r;
  logic [20:0]             s2_qest_r;
  logic signed [35:0]      s2_tprod_r;
  logic signed [RAW_W-1:0] s2_traw_r;

  logic              ready1;
  logic              ready2;
  logic [24:0]       pofs;
  logic [50:0]       qprod;
  logic signed [35:0] tprod;
  logic [24:0]       qx15;
  logic [24:0]       rem;
  logic              fix;
  logic [20:0]       qfix;
  logic [3:0]        rem_b;
  logic [31:0]       psc_bits;
  logic signed [36:0] tsum;

  assign ready2    = !s2_vld_r || item_ready;
  assign ready1    = !s1_vld_r || ready2;
  assign in_tready = ready1;

  // Biasing the reading by 15 * 2^20 makes it positive, so the division by
  // 15 becomes an unsigned reciprocal multiply that is at most one low.
  assign pofs  = 25'($signed(s1_praw_r)) + POFFSET;
  assign qprod = 51'(pofs) * 51'(RECIP15);
  assign tprod = 36'(s1_traw_r) * 36'(coef.c1);

  assign qx15  = {s2_qest_r, 4'b0000} - {4'b0000, s2_qest_r};
  assign rem   = s2_pofs_r - qx15;
  assign fix   = (rem >= 25'd15);
  assign qfix  = s2_qest_r + 21'(fix);
  assign rem_b = fix ? 4'(rem - 25'd15) : rem[3:0];

  // psc = 2048 * floor(praw / 15) + floor(2048 * (praw mod 15) / 15)
  assign psc_bits = ((32'(qfix) - QBIAS) << 11) + 32'(frac_tab(rem_b));

  // temperature_out = floor((c0 * 2^18 + c1 * traw) / 2^11)
  assign tsum = (37'(coef.c0) <<< 18) + 37'(s2_tprod_r);

  assign item_valid = s2_vld_r;
  assign item.traw  = s2_traw_r;
  assign item.psc   = psc_bits;
  assign item.tout  = tsum[35:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (ready1) begin
        s1_vld_r <= in_tvalid;
      end
      if (ready2) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_tvalid) begin
      s1_praw_r <= in_tdata[RAW_W-1:0];
      s1_traw_r <= in_tdata[2*RAW_W-1:RAW_W];
    end
    if (ready2 && s1_vld_r) begin
      s2_pofs_r  <= pofs;
      s2_qest_r  <= qprod[49:29];
      s2_tprod_r <= tprod;
      s2_traw_r  <= s1_traw_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bsc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_fifo (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push_valid,
  output logic                     push_ready,
  input  wire bsc_pkg::bsc_item_t  push_item,
  output logic                     pop_valid,
  input  wire                      pop,
  output bsc_pkg::bsc_item_t       pop_item
);
  import bsc_pkg::*;

  localparam int CNT_W = FIFO_AW + 1;

  bsc_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r;
  logic [FIFO_AW-1:0] rptr_r;
  logic [CNT_W-1:0]   count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r < CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire bsc_pkg::bsc_coef_t       coef,
  input  wire                           item_valid,
  output logic                          item_pop,
  input  wire bsc_pkg::bsc_item_t       item,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [bsc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bsc_pkg::*;

  localparam int ACC_W  = 88;
  localparam int PROD_W = 62;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(14);

  // Multiplier operand selects.
  localparam logic [1:0] A_PSC  = 2'd0;
  localparam logic [1:0] A_TRAW = 2'd1;
  localparam logic [1:0] A_QLO  = 2'd2;
  localparam logic [1:0] A_QHI  = 2'd3;

  localparam logic [3:0] B_C30      = 4'd0;
  localparam logic [3:0] B_TRAW     = 4'd1;
  localparam logic [3:0] B_C21      = 4'd2;
  localparam logic [3:0] B_C01      = 4'd3;
  localparam logic [3:0] B_INNER_LO = 4'd4;
  localparam logic [3:0] B_INNER_HI = 4'd5;
  localparam logic [3:0] B_MID_LO   = 4'd6;
  localparam logic [3:0] B_MID_HI   = 4'd7;
  localparam logic [3:0] B_W_LO     = 4'd8;
  localparam logic [3:0] B_W_HI     = 4'd9;

  // Partial product alignment.
  localparam logic [2:0] SH_0  = 3'd0;
  localparam logic [2:0] SH_11 = 3'd1;
  localparam logic [2:0] SH_28 = 3'd2;
  localparam logic [2:0] SH_32 = 3'd3;
  localparam logic [2:0] SH_60 = 3'd4;

  // Result scaling.
  localparam logic [1:0] RS_0  = 2'd0;
  localparam logic [1:0] RS_19 = 2'd1;
  localparam logic [1:0] RS_30 = 2'd2;

  // Accumulator preload.
  localparam logic [2:0] INIT_ZERO = 3'd0;
  localparam logic [2:0] INIT_C20  = 3'd1;
  localparam logic [2:0] INIT_C10  = 3'd2;
  localparam logic [2:0] INIT_C11  = 3'd3;
  localparam logic [2:0] INIT_C00  = 3'd4;

  // Result destinations.
  localparam logic [2:0] D_NONE  = 3'd0;
  localparam logic [2:0] D_INNER = 3'd1;
  localparam logic [2:0] D_Q     = 3'd2;
  localparam logic [2:0] D_MID   = 3'd3;
  localparam logic [2:0] D_W     = 3'd4;
  localparam logic [2:0] D_PADD  = 3'd5;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [2:0] sh;
    logic [2:0] init;
    logic [1:0] rs;
    logic [2:0] dest;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [3:0] b_sel;
    mac_ctl_t   ctl;
  } step_t;

  function automatic step_t mk_step(input logic [1:0] a_sel, input logic [3:0] b_sel,
                                    input logic [2:0] sh, input logic first,
                                    input logic last, input logic [2:0] init,
                                    input logic [1:0] rs, input logic [2:0] dest);
    step_t s;
    s.a_sel     = a_sel;
    s.b_sel     = b_sel;
    s.ctl.vld   = 1'b1;
    s.ctl.first = first;
    s.ctl.last  = last;
    s.ctl.sh    = sh;
    s.ctl.init  = init;
    s.ctl.rs    = rs;
    s.ctl.dest  = dest;
    return s;
  endfunction

  logic                     busy_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [31:0]       psc_r;
  logic signed [RAW_W-1:0]  traw_r;
  logic signed [TEMP_W-1:0] tout_r;
  logic signed [47:0]       inner_r;
  logic signed [35:0]       q_r;
  logic signed [55:0]       mid_r;
  logic signed [47:0]       w_r;
  logic signed [55:0]       psum_r;
  logic signed [55:0]       term_r;
  logic                     term_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic [TEMP_W-1:0]        out_temp_r;
  logic [PRES_W-1:0]        out_pres_r;

  step_t                    cur;
  logic signed [32:0]       a_op;
  logic signed [28:0]       b_op;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  init_val;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_shr;
  logic                     out_free;
  logic                     finishing;
  logic                     start;

  assign out_free  = !out_valid_r || out_tready;
  assign finishing = busy_r && (step_r == LAST_STEP) && out_free;
  assign start     = item_valid && (!busy_r || finishing);
  assign item_pop  = start;

  // Schedule of the pressure polynomial. A step's product is registered, then
  // summed by the accumulator into its destination register before a later step reads it.
  always_comb begin
    cur = '0;
    case (step_r)
      4'd0:  cur = mk_step(A_PSC, B_C30, SH_0, 1'b1, 1'b1, INIT_C20, RS_0, D_INNER);
      4'd1:  cur = mk_step(A_PSC, B_TRAW, SH_0, 1'b1, 1'b1, INIT_ZERO, RS_19, D_Q);
      4'd2:  cur = mk_step(A_PSC, B_INNER_LO, SH_0, 1'b1, 1'b0, INIT_C10, RS_0, D_NONE);
      4'd3:  cur = mk_step(A_PSC, B_INNER_HI, SH_28, 1'b0, 1'b1, INIT_ZERO, RS_30, D_MID);
      4'd4:  cur = mk_step(A_PSC, B_C21, SH_0, 1'b1, 1'b1, INIT_C11, RS_0, D_W);
      4'd5:  cur = mk_step(A_PSC, B_MID_LO, SH_0, 1'b1, 1'b0, INIT_C00, RS_0, D_NONE);
      4'd6:  cur = mk_step(A_PSC, B_MID_HI, SH_28, 1'b0, 1'b1, INIT_ZERO, RS_30, D_PADD);
      4'd7:  cur = mk_step(A_TRAW, B_C01, SH_11, 1'b1, 1'b1, INIT_ZERO, RS_0, D_PADD);
      4'd8:  cur = mk_step(A_QLO, B_W_LO, SH_0, 1'b1, 1'b0, INIT_ZERO, RS_0, D_NONE);
      4'd9:  cur = mk_step(A_QHI, B_W_LO, SH_32, 1'b0, 1'b0, INIT_ZERO, RS_0, D_NONE);
      4'd10: cur = mk_step(A_QLO, B_W_HI, SH_28, 1'b0, 1'b0, INIT_ZERO, RS_0, D_NONE);
      4'd11: cur = mk_step(A_QHI, B_W_HI, SH_60, 1'b0, 1'b1, INIT_ZERO, RS_30, D_PADD);
      default: cur = '0;
    endcase
    if (!busy_r) begin
      cur.ctl.vld = 1'b0;
    end
  end

  always_comb begin
    case (cur.a_sel)
      A_PSC:   a_op = 33'(psc_r);
      A_TRAW:  a_op = 33'(traw_r);
      A_QLO:   a_op = {1'b0, q_r[31:0]};
      A_QHI:   a_op = 33'($signed(q_r[35:32]));
      default: a_op = '0;
    endcase
    case (cur.b_sel)
      B_C30:      b_op = 29'(coef.c30);
      B_TRAW:     b_op = 29'(traw_r);
      B_C21:      b_op = 29'(coef.c21);
      B_C01:      b_op = 29'(coef.c01);
      B_INNER_LO: b_op = {1'b0, inner_r[27:0]};
      B_INNER_HI: b_op = 29'($signed(inner_r[47:28]));
      B_MID_LO:   b_op = {1'b0, mid_r[27:0]};
      B_MID_HI:   b_op = 29'($signed(mid_r[55:28]));
      B_W_LO:     b_op = {1'b0, w_r[27:0]};
      B_W_HI:     b_op = 29'($signed(w_r[47:28]));
      default:    b_op = '0;
    endcase
  end

  // Sums run modulo 2^88; every finished value is known to fit, so the
  // wrapped high parts of the shifted partial products cancel out.
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (ctl_r.sh)
      SH_0:    addend = prod_ext;
      SH_11:   addend = prod_ext <<< 11;
      SH_28:   addend = prod_ext <<< 28;
      SH_32:   addend = prod_ext <<< 32;
      SH_60:   addend = prod_ext <<< 60;
      default: addend = prod_ext;
    endcase
    case (ctl_r.init)
      INIT_C20: init_val = ACC_W'(coef.c20) <<< 30;
      INIT_C10: init_val = ACC_W'(coef.c10) <<< 60;
      INIT_C11: init_val = ACC_W'(coef.c11) <<< 30;
      INIT_C00: init_val = ACC_W'(coef.c00) <<< 60;
      default:  init_val = '0;
    endcase
    acc_nxt = (ctl_r.first ? init_val : acc_r) + addend;
    case (ctl_r.rs)
      RS_19:   acc_shr = acc_nxt >>> 19;
      RS_30:   acc_shr = acc_nxt >>> 30;
      default: acc_shr = acc_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      ctl_r       <= '0;
      term_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (finishing) begin
        busy_r <= 1'b0;
      end else if (busy_r && (step_r != LAST_STEP)) begin
        step_r <= step_r + 1'b1;
      end
      ctl_r      <= cur.ctl;
      term_vld_r <= ctl_r.vld && ctl_r.last && (ctl_r.dest == D_PADD);
      if (finishing) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      psc_r  <= item.psc;
      traw_r <= item.traw;
      tout_r <= item.tout;
    end
    prod_r <= PROD_W'(a_op) * PROD_W'(b_op);
    if (ctl_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (ctl_r.vld && ctl_r.last) begin
      case (ctl_r.dest)
        D_INNER: inner_r <= acc_shr[47:0];
        D_Q:     q_r     <= acc_shr[35:0];
        D_MID:   mid_r   <= acc_shr[55:0];
        D_W:     w_r     <= acc_shr[47:0];
        default: ;
      endcase
    end
    term_r <= acc_shr[55:0];
    if (start) begin
      psum_r <= '0;
    end else if (term_vld_r) begin
      psum_r <= psum_r + term_r;
    end
    // The terms of the sum stay below 2^52 in magnitude, so the pressure
    // always lies inside the 32-bit range; bits [55:24] are taken without saturation.
    if (finishing) begin
      out_temp_r <= tout_r;
      out_pres_r <= psum_r[55:24];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_pres_r, out_temp_r};

endmodule

`default_nettype wire

// File: rtl/barometer_sample_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// The back end handles one beat at a time in a 15-step multiply-accumulate sequence,
// which pushes 12 partial products through one 33x29 multiplier. It pops the next
// beat from the queue as it finishes the last one, once the output is free.
// The front end takes a beat every cycle until its four-entry queue fills.
// Reset: synchronous, active low; clears all handshake state and sets every
// coefficient register to zero.

module barometer_sample_compensation (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  wire [bsc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [24:0] temperature_out, [56:25] pressure_out, [63:57] zero
  output logic [bsc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                              cfg_wr_en,
  input  wire [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bsc_pkg::*;

  logic [23:0] coef_c0_c1_r;
  logic [19:0] coef_c00_r;
  logic [19:0] coef_c10_r;
  logic [15:0] coef_c01_r;
  logic [15:0] coef_c11_r;
  logic [15:0] coef_c20_r;
  logic [15:0] coef_c21_r;
  logic [15:0] coef_c30_r;

  bsc_coef_t coef;
  logic      push_valid;
  logic      push_ready;
  bsc_item_t push_item;
  logic      pop_valid;
  logic      pop;
  bsc_item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_c0_c1_r <= '0;
      coef_c00_r   <= '0;
      coef_c10_r   <= '0;
      coef_c01_r   <= '0;
      coef_c11_r   <= '0;
      coef_c20_r   <= '0;
      coef_c21_r   <= '0;
      coef_c30_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_C0_C1: coef_c0_c1_r <= cfg_wdata;
        CFG_C00:   coef_c00_r   <= cfg_wdata[19:0];
        CFG_C10:   coef_c10_r   <= cfg_wdata[19:0];
        CFG_C01:   coef_c01_r   <= cfg_wdata[15:0];
        CFG_C11:   coef_c11_r   <= cfg_wdata[15:0];
        CFG_C20:   coef_c20_r   <= cfg_wdata[15:0];
        CFG_C21:   coef_c21_r   <= cfg_wdata[15:0];
        CFG_C30:   coef_c30_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign coef.c0  = coef_c0_c1_r[23:12];
  assign coef.c1  = coef_c0_c1_r[11:0];
  assign coef.c00 = coef_c00_r;
  assign coef.c10 = coef_c10_r;
  assign coef.c01 = coef_c01_r;
  assign coef.c11 = coef_c11_r;
  assign coef.c20 = coef_c20_r;
  assign coef.c21 = coef_c21_r;
  assign coef.c30 = coef_c30_r;

  bsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (push_valid),
    .item_ready (push_ready),
    .item       (push_item)
  );

  bsc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  bsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .item_valid (pop_valid),
    .item_pop   (pop),
    .item       (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
